// ----- src/smae_pkg.sv -----
package smae_pkg;

  localparam int unsigned STACK_DEPTH_DEF  = 1024;
  localparam int unsigned GLOBAL_SLOTS_DEF = 256;

  typedef enum logic [3:0] {
    CMD_HALT  = 4'd0,
    CMD_PUSHC = 4'd1,
    CMD_ADD   = 4'd2,
    CMD_SUB   = 4'd3,
    CMD_MUL   = 4'd4,
    CMD_DIV   = 4'd5,
    CMD_MOD   = 4'd6,
    CMD_RDINT = 4'd7,
    CMD_WRINT = 4'd8,
    CMD_RDCHR = 4'd9,
    CMD_WRCHR = 4'd10,
    CMD_PUSHG = 4'd11,
    CMD_POPG  = 4'd12
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK   = 3'd0,
    ST_HALT = 3'd1,
    ST_DIVZ = 3'd2,
    ST_BADG = 3'd3,
    ST_OVF  = 3'd4,
    ST_UNF  = 3'd5
  } status_e;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_INT  = 2'd1;
  localparam logic [1:0] KIND_CHR  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD1,
    S_RD2,
    S_DIV,
    S_DONE
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture instruction
    logic rd_top;    // read stack[sp-1]
    logic rd_next;   // read stack[sp-2]
    logic div_start;
    logic finish;    // commit and present result
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic need_two;
    logic is_div;
    logic div_busy;
    logic early;     // result known without stack reads
  } stat_t;

endpackage

// ----- src/smae_if.sv -----
interface smae_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  cmd;
  logic signed [31:0] operand;
  logic signed [31:0] read_value;
  modport source (output valid, cmd, operand, read_value, input ready);
  modport sink   (input valid, cmd, operand, read_value, output ready);
endinterface

interface smae_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [1:0]  out_kind;
  logic signed [31:0] out_data;
  logic [10:0] stack_depth;
  modport source (output valid, status, out_kind, out_data, stack_depth, input ready);
  modport sink   (input valid, status, out_kind, out_data, stack_depth, output ready);
endinterface

interface smae_cfg_if;
  logic       valid;
  logic       ready;
  logic [8:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ----- src/smae_div.sv -----
module smae_div
  import smae_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  input  logic        want_rem_i,
  output logic        busy_o,
  output logic [31:0] res_o
);
  logic [31:0] q_q, q_d, r_q, r_d, d_q, d_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        na_q, na_d, nq_q, nq_d, rem_q, rem_d;
  logic [32:0] trial;

  always_comb begin
    q_d = q_q; r_d = r_q; d_d = d_q; cnt_d = cnt_q;
    na_d = na_q; nq_d = nq_q; rem_d = rem_q;
    trial = {r_q, q_q[31]} - {1'b0, d_q};
    if (start_i) begin
      q_d   = a_i[31] ? (32'd0 - a_i) : a_i;
      d_d   = b_i[31] ? (32'd0 - b_i) : b_i;
      r_d   = '0;
      cnt_d = 6'd32;
      na_d  = a_i[31];
      nq_d  = a_i[31] ^ b_i[31];
      rem_d = want_rem_i;
    end else if (cnt_q != 6'd0) begin
      // restoring step, one quotient bit per cycle
      if (!trial[32]) begin
        r_d = trial[31:0];
        q_d = {q_q[30:0], 1'b1};
      end else begin
        r_d = {r_q[30:0], q_q[31]};
        q_d = {q_q[30:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d; r_q <= r_d; d_q <= d_d;
    na_q <= na_d; nq_q <= nq_d; rem_q <= rem_d;
  end

  assign busy_o = (cnt_q != 6'd0);
  assign res_o  = rem_q ? (na_q ? (32'd0 - r_q) : r_q)
                        : (nq_q ? (32'd0 - q_q) : q_q);
endmodule

// ----- src/smae_ctrl.sv -----
module smae_ctrl
  import smae_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  input  stat_t stat_i,
  output ctrl_t ctrl_o
);
  state_e state_q, state_d;
  logic   ov_q, ov_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    ov_d    = ov_q;
    if (out_ready_i) ov_d = 1'b0;
    // new item only once the output register is free
    in_ready_o = (state_q == S_IDLE) && (!ov_q || out_ready_i);
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          ctrl_o.load = 1'b1;
          state_d = S_RD1;
        end
      end
      S_RD1: begin
        if (stat_i.early) begin
          state_d = S_DONE;
        end else begin
          ctrl_o.rd_top = 1'b1;
          state_d = stat_i.need_two ? S_RD2 : S_DONE;
        end
      end
      S_RD2: begin
        ctrl_o.rd_next = 1'b1;
        state_d = S_DIV;
      end
      S_DIV: begin
        if (stat_i.is_div) begin
          ctrl_o.div_start = 1'b1;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!stat_i.div_busy) begin
          ctrl_o.finish = 1'b1;
          ov_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_o = ov_q;

  a_fin_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.finish |=> state_q == S_IDLE && out_valid_o)
    else $error("finish did not present result");
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.load |-> (!ov_q || out_ready_i))
    else $error("load while result pending");
  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.div_start |=> state_q == S_DONE && !ctrl_o.finish)
    else $error("finish too early after divide start");
endmodule

// ----- src/smae_dp.sv -----
module smae_dp
  import smae_pkg::*;
#(
  parameter int unsigned STACK_DEPTH  = STACK_DEPTH_DEF,
  parameter int unsigned GLOBAL_SLOTS = GLOBAL_SLOTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ctrl_t       ctrl_i,
  output stat_t       stat_o,
  input  logic [3:0]  cmd_i,
  input  logic [31:0] operand_i,
  input  logic [31:0] read_value_i,
  input  logic        cfg_we_i,
  input  logic [8:0]  cfg_data_i,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [1:0]  out_kind_o,
  output logic [31:0] out_data_o,
  output logic [10:0] stack_depth_o
);
  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int GAW = (GLOBAL_SLOTS > 1) ? $clog2(GLOBAL_SLOTS) : 1;
  localparam int GCW = $clog2(GLOBAL_SLOTS + 1);

  logic [31:0] stack_mem [STACK_DEPTH];
  logic [31:0] glob_mem  [GLOBAL_SLOTS];
  logic [GLOBAL_SLOTS-1:0] gvalid_q;

  logic [SPW-1:0] sp_q;
  logic           stopped_q;
  logic [2:0]     code_q;
  logic [8:0]     gcount_q;
  logic [3:0]     cmd_q;
  logic [31:0]    opnd_q, rv_q;
  logic [31:0]    b_q, a_q, rd_q, g_q;
  logic           gv_q;
  logic [31:0]    mul_q, sum_q, dif_q;
  logic [2:0]     st_q, st_d;
  logic [1:0]     kind_q;
  logic [31:0]    data_q;
  logic [10:0]    depth_q;

  logic [31:0] div_res;
  logic        div_busy;

  // effective global count and index check
  logic [GCW:0] lim;
  logic         gbad;
  logic [GAW-1:0] gidx;
  assign lim  = (32'(gcount_q) > GLOBAL_SLOTS) ?
                (GCW+1)'(GLOBAL_SLOTS) : (GCW+1)'(gcount_q);
  assign gbad = opnd_q[31] || ({1'b0, opnd_q} >= {{(33-GCW-1){1'b0}}, lim});
  assign gidx = opnd_q[GAW-1:0];

  logic full, lt1, lt2;
  assign full = (sp_q == SPW'(STACK_DEPTH));
  assign lt1  = (sp_q == '0);
  assign lt2  = (sp_q < SPW'(2));

  // status decided right after load, before any stack read
  always_comb begin
    st_d = ST_OK;
    if (stopped_q) st_d = code_q;
    else begin
      case (cmd_q)
        CMD_HALT: st_d = ST_HALT;
        CMD_PUSHC, CMD_RDINT, CMD_RDCHR: if (full) st_d = ST_OVF;
        CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_MOD: if (lt2) st_d = ST_UNF;
        CMD_WRINT, CMD_WRCHR: if (lt1) st_d = ST_UNF;
        CMD_PUSHG: if (gbad) st_d = ST_BADG; else if (full) st_d = ST_OVF;
        CMD_POPG: if (lt1) st_d = ST_UNF; else if (gbad) st_d = ST_BADG;
        default: st_d = ST_OK;
      endcase
    end
  end

  logic two, one_rd;
  always_comb begin
    two    = (cmd_q inside {CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_MOD});
    one_rd = two || (cmd_q inside {CMD_WRINT, CMD_WRCHR, CMD_POPG});
  end

  assign stat_o.need_two = two;
  assign stat_o.is_div   = (cmd_q == CMD_DIV || cmd_q == CMD_MOD) && (b_q != 32'd0);
  assign stat_o.div_busy = div_busy;
  assign stat_o.early    = (st_d != ST_OK) || !one_rd;

  smae_div u_div (
    .clk_i, .rst_ni,
    .start_i   (ctrl_i.div_start),
    .a_i       (a_q),
    .b_i       (b_q),
    .want_rem_i(cmd_q == CMD_MOD),
    .busy_o    (div_busy),
    .res_o     (div_res)
  );

  logic [SAW-1:0] top_a, nxt_a, push_a;
  assign top_a  = SAW'(sp_q - SPW'(1));
  assign nxt_a  = SAW'(sp_q - SPW'(2));
  assign push_a = SAW'(sp_q);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q <= cmd_i; opnd_q <= operand_i; rv_q <= read_value_i;
    end
    if (ctrl_i.rd_top) b_q <= stack_mem[top_a];
    if (ctrl_i.rd_next) a_q <= stack_mem[nxt_a];
    rd_q <= stack_mem[top_a];
    g_q  <= glob_mem[gidx];
    gv_q <= gvalid_q[gidx];
    mul_q <= a_q * b_q;
    sum_q <= a_q + b_q;
    dif_q <= a_q - b_q;
  end

  // final status, re-evaluated with the divisor known
  logic [2:0]  fst;
  logic [31:0] res, pushv;
  always_comb begin
    fst = st_q;
    if (st_q == ST_OK && !stopped_q && (cmd_q == CMD_DIV || cmd_q == CMD_MOD)
        && b_q == 32'd0) fst = ST_DIVZ;
    case (cmd_q)
      CMD_ADD: res = sum_q;
      CMD_SUB: res = dif_q;
      CMD_MUL: res = mul_q;
      default: res = div_res;
    endcase
    case (cmd_q)
      CMD_PUSHC: pushv = opnd_q;
      CMD_RDINT: pushv = rv_q;
      CMD_RDCHR: pushv = {{24{rv_q[7]}}, rv_q[7:0]};
      default:   pushv = gv_q ? g_q : 32'd0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d;
    if (ctrl_i.finish && !stopped_q && fst == ST_OK) begin
      case (cmd_q)
        CMD_PUSHC, CMD_RDINT, CMD_RDCHR, CMD_PUSHG: stack_mem[push_a] <= pushv;
        CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_MOD: stack_mem[nxt_a] <= res;
        CMD_POPG: glob_mem[gidx] <= b_q;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q <= '0; stopped_q <= 1'b0; code_q <= ST_OK; gcount_q <= '0;
      gvalid_q <= '0;
    end else begin
      if (cfg_we_i) gcount_q <= cfg_data_i;
      if (ctrl_i.finish && !stopped_q) begin
        if (fst != ST_OK) begin
          stopped_q <= 1'b1; code_q <= fst;
        end else begin
          case (cmd_q)
            CMD_PUSHC, CMD_RDINT, CMD_RDCHR, CMD_PUSHG: sp_q <= sp_q + SPW'(1);
            CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_MOD,
            CMD_WRINT, CMD_WRCHR: sp_q <= sp_q - SPW'(1);
            CMD_POPG: begin
              sp_q <= sp_q - SPW'(1);
              gvalid_q[gidx] <= 1'b1;
            end
            default: ;
          endcase
        end
      end
    end
  end

  logic [SPW-1:0] sp_n;
  always_comb begin
    sp_n = sp_q;
    if (!stopped_q && fst == ST_OK) begin
      case (cmd_q)
        CMD_PUSHC, CMD_RDINT, CMD_RDCHR, CMD_PUSHG: sp_n = sp_q + SPW'(1);
        CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_MOD,
        CMD_WRINT, CMD_WRCHR, CMD_POPG: sp_n = sp_q - SPW'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.finish) begin
      kind_q  <= KIND_NONE;
      data_q  <= '0;
      if (!stopped_q && fst == ST_OK && cmd_q == CMD_WRINT) begin
        kind_q <= KIND_INT; data_q <= b_q;
      end
      if (!stopped_q && fst == ST_OK && cmd_q == CMD_WRCHR) begin
        kind_q <= KIND_CHR; data_q <= b_q;
      end
      depth_q <= 11'(sp_n);
    end
  end

  logic [2:0] ost_q;
  always_ff @(posedge clk_i) begin
    if (ctrl_i.finish) ost_q <= fst;
  end

  assign status_o      = ost_q;
  assign out_kind_o    = kind_q;
  assign out_data_o    = data_q;
  assign stack_depth_o = depth_q;

  logic unused;
  assign unused = out_ready_i ^ rd_q[0];

  a_sp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SPW'(STACK_DEPTH))
    else $error("stack pointer beyond depth");
  a_stop_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stopped_q |=> stopped_q && $stable(sp_q) && $stable(code_q))
    else $error("stopped machine changed state");
  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stopped_q |-> code_q != ST_OK)
    else $error("stopped with ok code");
endmodule

// ----- src/stack_machine_alu_executor.sv -----
// Stack-machine instruction executor.
// Channels: in_if carries one instruction (cmd, operand, read_value) per
// transaction; out_if returns one result (status, out_kind, out_data,
// stack_depth) per instruction, in order. cfg_if writes global_count and
// is always ready; write it only while no instruction is in flight.
// Sequence: an accepted instruction passes S_RD1 and S_DONE for pushes,
// pops, no-ops and errors found up front; add/sub/mul and a zero divisor
// pass S_RD1, S_RD2, S_DIV and S_DONE; div/mod pass the same states and
// wait in S_DONE for the radix-2 divider (one quotient bit per cycle, 32
// steps). One instruction at a time; the next is accepted once the result
// register is free or being taken in the same cycle.
// Reset: empty stack, globals read as zero, machine running, count 0.
// A stalled receiver holds the result steady; no new instruction is
// taken while it waits.
module stack_machine_alu_executor
  import smae_pkg::*;
#(
  parameter int unsigned STACK_DEPTH  = STACK_DEPTH_DEF,
  parameter int unsigned GLOBAL_SLOTS = GLOBAL_SLOTS_DEF
) (
  input logic       clk_i,
  input logic       rst_ni,
  smae_in_if.sink   in_if,
  smae_out_if.source out_if,
  smae_cfg_if.sink  cfg_if
);
  ctrl_t ctrl;
  stat_t stat;

  assign cfg_if.ready = 1'b1;

  smae_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .out_valid_o(out_if.valid),
    .out_ready_i(out_if.ready),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  smae_dp #(.STACK_DEPTH(STACK_DEPTH), .GLOBAL_SLOTS(GLOBAL_SLOTS)) u_dp (
    .clk_i, .rst_ni,
    .ctrl_i       (ctrl),
    .stat_o       (stat),
    .cmd_i        (in_if.cmd),
    .operand_i    (in_if.operand),
    .read_value_i (in_if.read_value),
    .cfg_we_i     (cfg_if.valid),
    .cfg_data_i   (cfg_if.data),
    .out_ready_i  (out_if.ready),
    .status_o     (out_if.status),
    .out_kind_o   (out_if.out_kind),
    .out_data_o   (out_if.out_data),
    .stack_depth_o(out_if.stack_depth)
  );
endmodule
